>>> design/rreq_pkg.sv
package rreq_pkg;

  // Fixed widths of the channel fields
  localparam int FIELD_W = 11;
  localparam int OP_W    = 2;

  // Depth of the service list
  localparam int MAX_PEOPLE = 1024;

  // Population after reset
  localparam int POP_RESET = 1024;

  // Command codes
  localparam logic [OP_W-1:0] OP_SERVE    = 2'd0;
  localparam logic [OP_W-1:0] OP_EXPEDITE = 2'd1;
  localparam logic [OP_W-1:0] OP_RESTART  = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]    operation;
    logic [FIELD_W-1:0] requester_id;
  } in_word_t;

  typedef struct packed {
    logic [FIELD_W-1:0] served_id;
  } out_word_t;

  typedef struct packed {
    logic [FIELD_W-1:0] population;
  } cfg_word_t;

  // Broadcast controls from the sequencer to every cell
  typedef struct packed {
    logic rebuild;   // load own position + 1
    logic rotate;    // front goes to the back of the live part
    logic move;      // shift right up to the found place, key enters at the front
    logic capture;   // register the key compare
  } cell_ctrl_t;

endpackage

>>> design/rreq_chan_if.sv
interface rreq_chan_if
  import rreq_pkg::*;
#(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

>>> design/rreq_cell.sv
module rreq_cell
  import rreq_pkg::*;
#(
  parameter int IdW   = 11,
  parameter int PosW  = 10,
  parameter int Index = 0
) (
  input  logic            clk,
  input  logic            rst_n,
  input  cell_ctrl_t      ctrl,
  input  logic [IdW-1:0]  front,
  input  logic [IdW-1:0]  prev_val,
  input  logic [IdW-1:0]  next_val,
  input  logic [IdW-1:0]  key,
  input  logic [PosW-1:0] pos,
  input  logic [PosW-1:0] pop_last,
  output logic [IdW-1:0]  val_r,
  output logic            match_r
);

  localparam logic [PosW-1:0] IDX  = PosW'(Index);
  localparam logic [IdW-1:0]  SEED = IdW'(Index + 1);

  logic [IdW-1:0] val_nxt;

  always_comb begin
    val_nxt = val_r;
    if (ctrl.rebuild) begin
      val_nxt = SEED;
    end else if (ctrl.rotate) begin
      if (IDX < pop_last) begin
        val_nxt = next_val;
      end else if (IDX == pop_last) begin
        val_nxt = front;
      end
    end else if (ctrl.move) begin
      // cell 0 sees the key on its left input
      if (IDX <= pos) begin
        val_nxt = prev_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      val_r <= SEED;
    end else begin
      val_r <= val_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.capture) begin
      match_r <= (val_r == key);
    end
  end

endmodule

>>> design/rreq_locate.sv
module rreq_locate
  import rreq_pkg::*;
#(
  parameter int Depth = 1024,
  parameter int PosW  = 10
) (
  input  logic             clk,
  input  logic [Depth-1:0] match,
  output logic [PosW-1:0]  pos_r
);

  logic [PosW-1:0] pos_c;

  // Exactly one cell matches: OR the indexes of the set bits
  always_comb begin
    pos_c = '0;
    for (int i = 0; i < Depth; i++) begin
      if (match[i]) begin
        pos_c = pos_c | PosW'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    pos_r <= pos_c;
  end

endmodule

>>> design/round_robin_expedite_queue.sv
// Move-to-front round-robin service list of requester ids 1..population.
//
// in_word   : command word {operation, requester_id}. Serve answers with the
//             id at the front and sends it to the back; expedite moves the id
//             to the front; restart rebuilds the order 1..population.
// out_word  : one word {served_id} for each serve command, in command order.
// cfg_word  : population write (0 acts as 1, above MaxPeople as MaxPeople);
//             the write also rebuilds the order. Taken only while idle.
//
// The list lives in a row of MaxPeople cells, one id per cell. Serve and
// restart finish in the cycle they are accepted, and a served id is
// written into the output buffer. Expedite runs in steps: every
// cell registers its key compare, the position encoder registers the place
// of the match, then the cells up to that place shift right by one.
// A two-word output buffer lets commands keep flowing while the receiver
// stalls; in_word.ready drops only while both words wait or an expedite
// is in flight. Reset loads population 1024 (clamped) and the order 1..N.
module round_robin_expedite_queue
  import rreq_pkg::*;
#(
  parameter int MaxPeople = MAX_PEOPLE
) (
  input  logic        clk,
  input  logic        rst_n,
  rreq_chan_if.sink   in_word,
  rreq_chan_if.source out_word,
  rreq_chan_if.sink   cfg_word
);

  localparam int IdW   = $clog2(MaxPeople + 1);
  localparam int PosW  = $clog2(MaxPeople);
  localparam int WideW = (IdW > FIELD_W) ? IdW : FIELD_W;
  localparam int PopRst = (POP_RESET > MaxPeople) ? MaxPeople : POP_RESET;
  localparam logic [WideW-1:0] MAX_W = WideW'(MaxPeople);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_FIND = 3'b010,
    ST_MOVE = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  in_word_t  in_pl;
  cfg_word_t cfg_pl;
  logic      in_acc, cfg_acc, out_acc;

  logic [PosW-1:0] pop_last_r, pop_last_nxt;
  logic [IdW-1:0]  key_r, key_c;
  logic [PosW-1:0] pos_r;
  cell_ctrl_t      ctrl;

  logic [IdW-1:0]   cell_val [MaxPeople];
  logic [MaxPeople-1:0] match;

  logic [WideW-1:0] req_w, cfg_w;
  logic             id_ok;
  logic             push;

  // output buffer
  logic [FIELD_W-1:0] obuf_r [2];
  logic               wr_ptr_r, rd_ptr_r;
  logic [1:0]         cnt_r, cnt_nxt;

  assign in_pl  = in_word.payload;
  assign cfg_pl = cfg_word.payload;

  assign in_word.ready  = (state_r == ST_IDLE) && (cnt_r != 2'd2);
  assign cfg_word.ready = (state_r == ST_IDLE);

  assign in_acc  = in_word.valid && in_word.ready;
  assign cfg_acc = cfg_word.valid && cfg_word.ready;
  assign out_acc = out_word.valid && out_word.ready;

  assign req_w = WideW'(in_pl.requester_id);
  assign cfg_w = WideW'(cfg_pl.population);

  // Ids 1..population are in rotation; others are dropped
  assign id_ok = (req_w != '0) && ((req_w - 1'b1) <= WideW'(pop_last_r));

  // Compare against the incoming id on capture, the held key on the move
  assign key_c = (state_r == ST_IDLE) ? IdW'(in_pl.requester_id) : key_r;

  // Decode the command and sequence an expedite
  always_comb begin
    state_nxt = state_r;
    ctrl      = '0;
    push      = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          unique case (in_pl.operation)
            OP_SERVE: begin
              ctrl.rotate = 1'b1;
              push        = 1'b1;
            end
            OP_EXPEDITE: begin
              if (id_ok) begin
                ctrl.capture = 1'b1;
                state_nxt    = ST_FIND;
              end
            end
            OP_RESTART: begin
              ctrl.rebuild = 1'b1;
            end
            default: begin
            end
          endcase
        end
        if (cfg_acc) begin
          ctrl.rebuild = 1'b1;
        end
      end
      ST_FIND: begin
        state_nxt = ST_MOVE;
      end
      ST_MOVE: begin
        ctrl.move = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Clamp the population write to 1..MaxPeople, hold it as population - 1
  always_comb begin
    pop_last_nxt = pop_last_r;
    if (cfg_acc) begin
      if (cfg_w == '0) begin
        pop_last_nxt = '0;
      end else if (cfg_w > MAX_W) begin
        pop_last_nxt = PosW'(MaxPeople - 1);
      end else begin
        pop_last_nxt = PosW'(cfg_w - 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      pop_last_r <= PosW'(PopRst - 1);
    end else begin
      state_r    <= state_nxt;
      pop_last_r <= pop_last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.capture) begin
      key_r <= IdW'(in_pl.requester_id);
    end
  end

  // Row of cells: each takes its right neighbor on rotate, its left on move
  for (genvar g = 0; g < MaxPeople; g++) begin : g_cell
    logic [IdW-1:0] prev_c, next_c;
    if (g == 0) begin : g_first
      assign prev_c = key_c;
    end else begin : g_mid
      assign prev_c = cell_val[g-1];
    end
    if (g == MaxPeople - 1) begin : g_last
      assign next_c = cell_val[g];
    end else begin : g_body
      assign next_c = cell_val[g+1];
    end

    rreq_cell #(
      .IdW   (IdW),
      .PosW  (PosW),
      .Index (g)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctrl     (ctrl),
      .front    (cell_val[0]),
      .prev_val (prev_c),
      .next_val (next_c),
      .key      (key_c),
      .pos      (pos_r),
      .pop_last (pop_last_r),
      .val_r    (cell_val[g]),
      .match_r  (match[g])
    );
  end

  rreq_locate #(
    .Depth (MaxPeople),
    .PosW  (PosW)
  ) u_locate (
    .clk   (clk),
    .match (match),
    .pos_r (pos_r)
  );

  // Output buffer: push the front id on serve, pop on the handshake
  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !out_acc) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (!push && out_acc) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (out_acc) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      obuf_r[wr_ptr_r] <= FIELD_W'(cell_val[0]);
    end
  end

  assign out_word.valid             = (cnt_r != 2'd0);
  assign out_word.payload.served_id = obuf_r[rd_ptr_r];

  // An expedite always finishes: locate is followed by the shift
  a_find_then_move: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_FIND |=> state_r == ST_MOVE)
    else $error("expedite sequence skipped the shift");

  // After the shift the expedited id stands at the front
  a_key_at_front: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_MOVE |=> cell_val[0] == key_r)
    else $error("expedited id not at the front");

  // A restart puts id 1 at the front
  a_restart_front: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_pl.operation == OP_RESTART) |=> cell_val[0] == IdW'(1))
    else $error("restart did not rebuild the order");

  // The output buffer never holds more than two words
  a_obuf_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3)
    else $error("output buffer overflow");

endmodule
